// ----- rtl/pc_pkg.sv -----
// Shared types, widths and codes for the Pearson correlation block.
package pc_pkg;

    localparam int MAX_LEN_DEF      = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FIELD_W          = 16;
    localparam int SUM_W            = 29;
    localparam int SQ_W             = 45;
    localparam int CNT_W            = 17;
    localparam int PC_W             = 13;
    localparam int OP_W             = 64;
    localparam int PROD_W           = 128;
    localparam int Q_DEPTH          = 2;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_sample;
        logic signed [FIELD_W-1:0] y_sample;
        logic                      last_pair;
    } t_pair;

    typedef struct packed {
        logic signed [FIELD_W-1:0] correlation;
        logic [1:0]                status;
        logic [PC_W-1:0]           pair_count;
    } t_result;

    // Accumulated sums of one closed vector, handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SQ_W-1:0]  sxy;
        logic signed [SQ_W-1:0]  sxx;
        logic signed [SQ_W-1:0]  syy;
        logic                    ovf;
    } t_snap;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL_START,
        BS_MUL_WAIT,
        BS_DIV,
        BS_SQRT,
        BS_FINISH
    } t_back_state;

endpackage

// ----- rtl/pearson_correlation_top.sv -----
// A zero variance skips the last two products, the division and the root.
// Throughput: one pair per cycle while o_full is low. The back end works on one vector at a
// time with the shared 16-bit-digit multiplier, the 33-step divider and the 17-step root.
// A two-entry snapshot queue lets the front accept pairs while the back is busy.
// Reset (synchronous, active low) clears count, sums, queue and sequencer; the block
// accepts pairs as soon as reset is released.
module pearson_correlation_top #(
    parameter int MAX_LEN      = pc_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = pc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  pc_pkg::t_pair   i_pair,
    output logic            o_empty,
    input  logic            i_pop,
    output pc_pkg::t_result o_result
);

    logic          accept, q_push, q_pop, q_empty, q_full;
    pc_pkg::t_snap f_snap, q_snap;

    assign accept = i_push && !o_full;
    assign o_full = q_full;

    pc_front #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pair   (i_pair),
        .o_push   (q_push),
        .o_snap   (f_snap)
    );

    pc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_snap  (f_snap),
        .i_pop   (q_pop),
        .o_snap  (q_snap),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_snap    (q_snap),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (o_result)
    );

    // Status is never the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_result.status <= pc_pkg::ST_OVERFLOW)
        else $error("result status code out of range");

    // A zero-variance result carries a zero coefficient
    a_zero_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status == pc_pkg::ST_ZERO_VAR) |-> o_result.correlation == '0)
        else $error("zero variance result with non-zero coefficient");

    // Snapshot queue never written when full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("snapshot pushed into full queue");

    // Back end takes a snapshot only when one is waiting
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("snapshot popped from empty queue");

endmodule

// ----- rtl/pc_front.sv -----
// Front end: takes pairs, accumulates count and sums, hands a snapshot on the last pair.
module pc_front #(
    parameter int MAX_LEN      = pc_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = pc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  pc_pkg::t_pair i_pair,
    output logic          o_push,
    output pc_pkg::t_snap o_snap
);

    localparam int CntW = $clog2(MAX_LEN + 1);

    logic [CntW-1:0]                 r_cnt, n_cnt;
    logic signed [pc_pkg::SUM_W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [pc_pkg::SQ_W-1:0]  r_sxy, n_sxy, r_sxx, n_sxx, r_syy, n_syy;
    logic                            r_ovf, n_ovf;

    logic [SAMPLE_WIDTH+pc_pkg::FIELD_W-1:0] x_raw, y_raw;
    logic signed [SAMPLE_WIDTH-1:0]          xs, ys;
    logic signed [2*SAMPLE_WIDTH-1:0]        pxy, pxx, pyy;
    logic                                    keep;

    // Low bits of each field, sign extended from the sample width
    assign x_raw = {{SAMPLE_WIDTH{1'b0}}, i_pair.x_sample};
    assign y_raw = {{SAMPLE_WIDTH{1'b0}}, i_pair.y_sample};
    assign xs    = x_raw[SAMPLE_WIDTH-1:0];
    assign ys    = y_raw[SAMPLE_WIDTH-1:0];
    assign pxy   = xs * ys;
    assign pxx   = xs * xs;
    assign pyy   = ys * ys;
    assign keep  = r_cnt < CntW'(MAX_LEN);

    // Accumulate, or flag overflow once the length limit is reached
    always_comb begin
        n_cnt = r_cnt;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxy = r_sxy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        n_ovf = r_ovf;
        if (i_accept) begin
            if (!keep) begin
                n_ovf = 1'b1;
            end else begin
                n_cnt = r_cnt + CntW'(1);
                n_sx  = r_sx + pc_pkg::SUM_W'(xs);
                n_sy  = r_sy + pc_pkg::SUM_W'(ys);
                n_sxy = r_sxy + pc_pkg::SQ_W'(pxy);
                n_sxx = r_sxx + pc_pkg::SQ_W'(pxx);
                n_syy = r_syy + pc_pkg::SQ_W'(pyy);
            end
        end
    end

    assign o_push      = i_accept && i_pair.last_pair;
    assign o_snap.n    = pc_pkg::CNT_W'(n_cnt);
    assign o_snap.sx   = n_sx;
    assign o_snap.sy   = n_sy;
    assign o_snap.sxy  = n_sxy;
    assign o_snap.sxx  = n_sxx;
    assign o_snap.syy  = n_syy;
    assign o_snap.ovf  = n_ovf;

    // Sums clear on reset and after each closed vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxy <= n_sxy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_ovf <= n_ovf;
        end
    end

endmodule

// ----- rtl/pc_queue.sv -----
// Short snapshot queue between front and back ends.
module pc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pc_pkg::t_snap i_snap,
    input  logic          i_pop,
    output pc_pkg::t_snap o_snap,
    output logic          o_empty,
    output logic          o_full
);

    localparam int AddrW = (pc_pkg::Q_DEPTH > 1) ? $clog2(pc_pkg::Q_DEPTH) : 1;
    localparam int LvlW  = $clog2(pc_pkg::Q_DEPTH + 1);

    pc_pkg::t_snap r_mem [pc_pkg::Q_DEPTH];
    logic [AddrW-1:0] r_wr, r_rd;
    logic [LvlW-1:0]  r_lvl;

    assign o_empty = r_lvl == '0;
    assign o_full  = r_lvl == LvlW'(pc_pkg::Q_DEPTH);
    assign o_snap  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_snap;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AddrW'(pc_pkg::Q_DEPTH - 1)) ? '0 : r_wr + AddrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AddrW'(pc_pkg::Q_DEPTH - 1)) ? '0 : r_rd + AddrW'(1);
            end
            r_lvl <= r_lvl + LvlW'(i_push) - LvlW'(i_pop);
        end
    end

endmodule

// ----- rtl/pc_mul.sv -----
// Shared multi-cycle signed multiplier, 64 x 64 bits, one 16-bit digit per cycle.
module pc_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [pc_pkg::OP_W-1:0]   i_a,
    input  logic signed [pc_pkg::OP_W-1:0]   i_b,
    output logic                             o_done,
    output logic signed [pc_pkg::PROD_W-1:0] o_prod
);

    localparam int DigW   = 16;
    localparam int Digits = pc_pkg::OP_W / DigW;

    logic [pc_pkg::OP_W-1:0]        r_ua, r_ub;
    logic [pc_pkg::PROD_W-1:0]      r_acc;
    logic                           r_neg, r_busy, r_done;
    logic [2:0]                     r_cnt;
    logic signed [pc_pkg::PROD_W-1:0] r_prod;
    logic [pc_pkg::OP_W+DigW-1:0]   part;

    assign part   = r_ua * r_ub[pc_pkg::OP_W-1 -: DigW];
    assign o_done = r_done;
    assign o_prod = r_prod;

    // Control: busy flag, digit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 3'(Digits)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    // Magnitudes, most significant digit first, sign applied at the end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[pc_pkg::OP_W-1] ? -i_a : i_a;
            r_ub  <= i_b[pc_pkg::OP_W-1] ? -i_b : i_b;
            r_neg <= i_a[pc_pkg::OP_W-1] ^ i_b[pc_pkg::OP_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'(Digits)) begin
                r_prod <= r_neg ? -r_acc : r_acc;
            end else begin
                r_acc <= {r_acc[pc_pkg::PROD_W-DigW-1:0], {DigW{1'b0}}}
                       + pc_pkg::PROD_W'(part);
                r_ub  <= {r_ub[pc_pkg::OP_W-DigW-1:0], {DigW{1'b0}}};
            end
        end
    end

endmodule

// ----- rtl/pc_back.sv -----
// Back end: sequences products, long division and square root, holds the result.
module pc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  pc_pkg::t_snap   i_snap,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output pc_pkg::t_result o_result
);

    localparam int RemW = pc_pkg::PROD_W + 32;

    pc_pkg::t_back_state r_state, n_state;
    pc_pkg::t_snap       r_snap;
    logic [2:0]          r_step;
    logic [5:0]          r_cnt;
    logic                r_bad;
    logic [pc_pkg::OP_W-1:0] r_t1, r_num, r_vx, r_vy;
    logic [RemW-1:0]     r_rem, r_div;
    logic [32:0]         r_quo;
    logic [33:0]         r_tsrc;
    logic [17:0]         r_srem;
    logic [16:0]         r_root;
    logic                r_out_valid;
    pc_pkg::t_result     r_out, fin;

    logic                mul_start, mul_done, out_load;
    logic signed [pc_pkg::OP_W-1:0]   mul_a, mul_b;
    logic signed [pc_pkg::PROD_W-1:0] prod;
    logic [pc_pkg::OP_W-1:0] diff;
    logic                var_bad, ge;
    logic [32:0]         quo_nxt;
    logic [19:0]         srem_sh, trial;
    logic [17:0]         c_sum;
    logic [16:0]         cq, qv;

    pc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // Operand selection for each product step
    always_comb begin
        unique case (r_step)
            3'd0: begin mul_a = signed'(pc_pkg::OP_W'(r_snap.n)); mul_b = pc_pkg::OP_W'(r_snap.sxy); end
            3'd1: begin mul_a = pc_pkg::OP_W'(r_snap.sx); mul_b = pc_pkg::OP_W'(r_snap.sy); end
            3'd2: begin mul_a = signed'(pc_pkg::OP_W'(r_snap.n)); mul_b = pc_pkg::OP_W'(r_snap.sxx); end
            3'd3: begin mul_a = pc_pkg::OP_W'(r_snap.sx); mul_b = pc_pkg::OP_W'(r_snap.sx); end
            3'd4: begin mul_a = signed'(pc_pkg::OP_W'(r_snap.n)); mul_b = pc_pkg::OP_W'(r_snap.syy); end
            3'd5: begin mul_a = pc_pkg::OP_W'(r_snap.sy); mul_b = pc_pkg::OP_W'(r_snap.sy); end
            3'd6: begin mul_a = signed'(r_num); mul_b = signed'(r_num); end
            3'd7: begin mul_a = signed'(r_vx); mul_b = signed'(r_vy); end
        endcase
    end

    // Differences and variance check
    assign diff    = r_t1 - prod[pc_pkg::OP_W-1:0];
    assign var_bad = ($signed(r_vx) <= 0) || ($signed(diff) <= 0);

    // Division and root step logic
    assign ge      = r_rem >= r_div;
    assign quo_nxt = {r_quo[31:0], ge};
    assign srem_sh = {r_srem, r_tsrc[33:32]};
    assign trial   = {1'b0, r_root, 2'b01};

    // Round the root to the Q1.15 magnitude and build the result
    assign c_sum = {1'b0, r_root} + 18'd1;
    assign cq    = c_sum[17:1];
    assign qv    = (cq > 17'd32768) ? 17'd32768 : cq;
    always_comb begin
        fin.pair_count = r_snap.n[pc_pkg::PC_W-1:0];
        if (r_bad) begin
            fin.correlation = '0;
        end else if (r_num[pc_pkg::OP_W-1]) begin
            fin.correlation = 16'(17'd0 - qv);
        end else begin
            fin.correlation = (qv > 17'd32767) ? 16'h7fff : qv[15:0];
        end
        priority if (r_snap.ovf) begin
            fin.status = pc_pkg::ST_OVERFLOW;
        end else if (r_bad) begin
            fin.status = pc_pkg::ST_ZERO_VAR;
        end else begin
            fin.status = pc_pkg::ST_VALID;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pc_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            pc_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = pc_pkg::BS_MUL_START;
                end
            end
            pc_pkg::BS_MUL_START: begin
                mul_start = 1'b1;
                n_state   = pc_pkg::BS_MUL_WAIT;
            end
            pc_pkg::BS_MUL_WAIT: begin
                if (mul_done) begin
                    priority if (r_step == 3'd5 && var_bad) begin
                        n_state = pc_pkg::BS_FINISH;
                    end else if (r_step == 3'd7) begin
                        n_state = pc_pkg::BS_DIV;
                    end else begin
                        n_state = pc_pkg::BS_MUL_START;
                    end
                end
            end
            pc_pkg::BS_DIV: begin
                if (r_cnt == 6'd32) begin
                    n_state = pc_pkg::BS_SQRT;
                end
            end
            pc_pkg::BS_SQRT: begin
                if (r_cnt == 6'd16) begin
                    n_state = pc_pkg::BS_FINISH;
                end
            end
            pc_pkg::BS_FINISH: begin
                if (!r_out_valid || i_pop) begin
                    out_load = 1'b1;
                    n_state  = pc_pkg::BS_IDLE;
                end
            end
            default: n_state = pc_pkg::BS_IDLE;
        endcase
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_snap <= i_snap;
            r_step <= '0;
            r_bad  <= 1'b0;
        end
        if (r_state == pc_pkg::BS_MUL_WAIT && mul_done) begin
            r_step <= r_step + 3'd1;
            unique case (r_step)
                3'd0, 3'd2, 3'd4: r_t1 <= prod[pc_pkg::OP_W-1:0];
                3'd1: r_num <= diff;
                3'd3: r_vx  <= diff;
                3'd5: begin
                    r_vy  <= diff;
                    r_bad <= var_bad;
                end
                3'd6: r_rem <= {prod, 32'd0};
                3'd7: begin
                    r_div <= {prod, 32'd0};
                    r_quo <= '0;
                    r_cnt <= '0;
                end
            endcase
        end
        if (r_state == pc_pkg::BS_DIV) begin
            if (ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= quo_nxt;
            if (r_cnt == 6'd32) begin
                r_tsrc <= {1'b0, quo_nxt};
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
        if (r_state == pc_pkg::BS_SQRT) begin
            if (srem_sh >= trial) begin
                r_srem <= 18'(srem_sh - trial);
                r_root <= {r_root[15:0], 1'b1};
            end else begin
                r_srem <= srem_sh[17:0];
                r_root <= {r_root[15:0], 1'b0};
            end
            r_tsrc <= {r_tsrc[31:0], 2'b00};
            r_cnt  <= r_cnt + 6'd1;
        end
        if (out_load) begin
            r_out <= fin;
        end
    end

    // Result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule
